FILE: src/sha256_message_hasher_core_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 hasher assertion macros
// Shared concurrent assertion shorthands for the hasher modules.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Constants, round table and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // Front-to-back command: one byte slot with control flags
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } cmd_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: src/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-stream SHA-256 with standard padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Input stream: one transfer per message byte. s_axis_tdata carries msg_byte,
// tuser has_byte and tlast the end marker; an item with has_byte low and
// tlast high ends the message without adding a byte.
// Output stream: eight transfers per message, digest word 0 first; tuser
// carries the word index and tlast marks word 7.
// The back end packs each byte into the block words; the 64th byte of a block
// starts 64 rounds on the single round unit, followed by the hash add.
// After the end marker, padding fills the remaining byte slots in order, then
// one or two compressions run.
// A four-entry queue lets bytes keep arriving while rounds run.
// Reset returns the hash to the initial values and empties the queue.
// A stalled receiver holds the current digest word; the queue fills and
// then input tready falls.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_core_macros.svh"

module sha256_message_hasher_core #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte[7:0]
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word[31:0]
  output logic [2:0]  m_axis_tuser,   // word_index[2:0]
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::cmd_t in_cmd, q_cmd;
  logic          q_valid, q_ready;

  assign in_cmd.data     = s_axis_tdata;
  assign in_cmd.has_byte = s_axis_tuser;
  assign in_cmd.last     = s_axis_tlast;

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .cmd_valid_o(q_valid), .cmd_ready_i(q_ready), .cmd_o(q_cmd)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .digest_word_o(m_axis_tdata), .word_index_o(m_axis_tuser),
    .last_word_o(m_axis_tlast)
  );

  `SHA_ASSERT_IMP(a_last_idx, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
    m_axis_tuser == 3'd7, "tlast on wrong digest word")
  `SHA_ASSERT_IMP(a_last_only7, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == 3'd7,
    m_axis_tlast, "word 7 without tlast")

endmodule

FILE: src/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts input transfers, drops empty non-final items, queues commands.
// ----------------------------------------------------------------------------
module sha_front #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sha_pkg::cmd_t  in_cmd_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output sha_pkg::cmd_t  cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::cmd_t      mem_q [Depth];
  logic [AW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]        cnt_q, cnt_d;
  logic               push, pop, keep;

  // Items with neither byte nor end marker carry no work
  assign keep       = in_cmd_i.has_byte | in_cmd_i.last;
  assign in_ready_o = (cnt_q != Depth[AW:0]);
  assign push       = in_valid_i & in_ready_o & keep;
  assign pop        = cmd_valid_o & cmd_ready_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o      = mem_q[rd_q];

  // Advance pointers with wrap at depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

endmodule

FILE: src/sha_back.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher back end
// Packs bytes, pads, runs one compression round per cycle, emits digest.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_core_macros.svh"

module sha_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  sha_pkg::cmd_t  cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    digest_word_o,
  output logic [2:0]     word_index_o,
  output logic           last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_COMP, ST_ADD, ST_OUT
  } state_e;

  state_e       state_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   pos_q;
  logic [63:0]  bits_q;
  logic [5:0]   rnd_q;
  logic         pad_q;     // padding in progress
  logic         padlen_q;  // this block carries the length
  logic         pend_last_q;
  logic [2:0]   oidx_q;

  logic [7:0]   byte_in;
  logic         byte_go;
  logic [31:0]  wt, t1, t2, ch, mj, wn;
  logic [31:0]  packed_w;

  assign cmd_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // Round datapath with rolling schedule window
  assign wt = w_q[0];
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch + sha_pkg::RoundK[rnd_q] + wt;
  assign t2 = sha_pkg::bsig0(v_q[0]) + mj;
  assign wn = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];

  // Byte to write in this cycle
  always_comb begin
    byte_go = 1'b0;
    byte_in = '0;
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.has_byte) begin
      byte_go = 1'b1;
      byte_in = cmd_i.data;
    end else if (state_q == ST_PAD) begin
      byte_go = 1'b1;
      byte_in = pad_q ? 8'h00 : sha_pkg::PadByte;
    end
    packed_w = w_q[pos_q[5:2]];
    case (pos_q[1:0])
      2'd0:    packed_w = {byte_in, 24'h0};
      2'd1:    packed_w[23:16] = byte_in;
      2'd2:    packed_w[15:8]  = byte_in;
      default: packed_w[7:0]   = byte_in;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      bits_q   <= '0;
      rnd_q    <= '0;
      pad_q    <= 1'b0;
      padlen_q <= 1'b0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::IV[i];
        v_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.has_byte) begin
              bits_q <= bits_q + 64'd8;
              pos_q  <= pos_q + 6'd1;
            end
            pad_q <= 1'b0;
            if (cmd_i.has_byte && pos_q == 6'd63) begin
              state_q <= ST_COMP;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
              rnd_q <= '0;
              padlen_q <= 1'b0;
            end else if (cmd_i.last) begin
              state_q <= ST_PAD;
            end
            // A last byte filling the block pads after the compression
            if (cmd_i.last) pad_q <= 1'b0;
          end
        end
        ST_PAD: begin
          pad_q <= 1'b1;
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd55) begin
            state_q  <= ST_COMP;
            padlen_q <= 1'b1;
            rnd_q    <= '0;
            pos_q    <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          end else if (pos_q == 6'd63) begin
            state_q  <= ST_COMP;
            padlen_q <= 1'b0;
            rnd_q    <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          end
        end
        ST_COMP: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (padlen_q) begin
            state_q <= ST_OUT;
            oidx_q  <= '0;
          end else if (pad_q || pend_last_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              state_q  <= ST_IDLE;
              bits_q   <= '0;
              pos_q    <= '0;
              pad_q    <= 1'b0;
              padlen_q <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Remember an end marker that arrived with the block's final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_last_q <= 1'b0;
    end else if (state_q == ST_IDLE && cmd_valid_i) begin
      pend_last_q <= cmd_i.last & cmd_i.has_byte & (pos_q == 6'd63);
    end else if (state_q == ST_ADD) begin
      pend_last_q <= 1'b0;
    end
  end

  // Block words: byte packing, length insert, schedule roll during rounds
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMP) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end else if (state_q == ST_PAD && pos_q == 6'd55) begin
      w_q[13] <= packed_w;
      w_q[14] <= bits_q[63:32];
      w_q[15] <= bits_q[31:0];
    end else if (byte_go) begin
      w_q[pos_q[5:2]] <= packed_w;
    end
  end

  `SHA_ASSERT_IMP(a_out_only_in_out, clk_i, rst_ni, out_valid_o, !cmd_ready_o,
    "digest shown while accepting commands")
  `SHA_ASSERT_NXT(a_hold_word, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(word_index_o), "digest word changed under stall")
  `SHA_ASSERT_NXT(a_round_wrap, clk_i, rst_ni, state_q == ST_COMP && rnd_q == 6'd63,
    state_q == ST_ADD, "compression did not end after 64 rounds")

endmodule

FILE: sim/sha256_message_hasher_core_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher core testbench
// Streams byte messages into the hasher under several idle/stall patterns and
// checks every digest word against a behavioral SHA-256 digest calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_message_hasher_core_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandomItems = 90;

  // Test phases: idle percentages for sender and receiver
  typedef enum logic [1:0] {
    PhaseSteady, PhaseSenderIdle, PhaseRecvStall, PhaseBothIdle
  } phase_e;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
  } digest_item_t;

  // Directed row: expected first digest word given where it is well known
  typedef struct {
    byte_item_t  item;
    logic        has_known;
    logic [31:0] known_word0;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // msg_byte[7:0]
  logic        s_axis_tuser;    // has_byte
  logic        s_axis_tlast;    // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // digest_word[31:0]
  logic [2:0]  m_axis_tuser;    // word_index[2:0]
  logic        m_axis_tlast;    // last_word

  digest_item_t expected_words[$];
  logic [31:0]  run_hash [8];
  logic [31:0]  block_buf [16];
  logic [5:0]   byte_pos;
  logic [63:0]  bit_count;
  int unsigned  fail_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  sha256_message_hasher_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one compression over block_buf into run_hash
  task automatic compress_buf();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
               + sched[i-7] + sched[i-16]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3));
    end
    for (int i = 0; i < 8; i++) v[i] = run_hash[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) run_hash[i] += v[i];
  endtask

  task automatic append_byte(logic [7:0] b);
    if (byte_pos[1:0] == 2'd0) block_buf[byte_pos[5:2]] = '0;
    block_buf[byte_pos[5:2]] |= 32'(b) << ((3 - byte_pos[1:0]) * 8);
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress_buf();
  endtask

  task automatic hasher_reset();
    for (int i = 0; i < 8; i++) run_hash[i] = sha_pkg::IV[i];
    byte_pos  = '0;
    bit_count = '0;
  endtask

  // Advance the digest calculator by one accepted transfer
  task automatic predict_digest(byte_item_t it);
    if (it.has_byte) begin
      bit_count += 64'd8;
      append_byte(it.msg_byte);
    end
    if (it.last) begin
      append_byte(sha_pkg::PadByte);
      while (byte_pos != 6'd56) append_byte(8'h00);
      block_buf[14] = bit_count[63:32];
      block_buf[15] = bit_count[31:0];
      compress_buf();
      for (int i = 0; i < 8; i++)
        expected_words.push_back('{run_hash[i], 3'(i), i == 7});
      hasher_reset();
    end
  endtask

  // Drive one item and wait for its transfer, with random sender idling
  task automatic send_item(byte_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.msg_byte;
    s_axis_tuser  <= it.has_byte;
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digest(it);
  endtask

  task automatic send_message(int unsigned len, bit empty_end);
    for (int unsigned i = 0; i < len; i++)
      send_item('{8'($urandom), 1'b1, (i == len - 1) && !empty_end});
    if (empty_end || len == 0) send_item('{8'h00, 1'b0, 1'b1});
  endtask

  // Receiver stalls and result checking
  always @(posedge clk_i) begin
    digest_item_t got;
    digest_item_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, got.word, got.index);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: expected word %h idx %0d last %b, actual %h idx %0d last %b",
                     $time, want.word, want.index, want.last_word,
                     got.word, got.index, got.last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    int unsigned sent;
    int unsigned len;
    phase_e      phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hasher_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: empty message, ignored no-byte item, "abc", extremes
    rows.push_back('{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'he3b0c442});
    rows.push_back('{'{8'h5a, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h61, 1'b1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h62, 1'b1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h63, 1'b1, 1'b1}, 1'b1, 32'hba7816bf});
    rows.push_back('{'{8'hff, 1'b1, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'h00, 1'b1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hff, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'haa, 1'b1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h55, 1'b1, 1'b1}, 1'b0, '0});
    foreach (rows[r]) begin
      send_item(rows[r].item);
      if (rows[r].has_known && expected_words.size() > 0
          && expected_words[expected_words.size() - 8].word !== rows[r].known_word0) begin
        $display("%0t: expected word %h, actual %h", $time, rows[r].known_word0,
                 expected_words[expected_words.size() - 8].word);
        fail_count++;
      end
    end

    // Block boundaries: 56 bytes (long padding), 64 bytes ending on a full block
    send_message(56, 0);
    send_message(64, 0);

    // Hold off until every digest word is out
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);

    // Random messages across idle phases, mostly short, a few near a block
    sent = 0;
    while (sent < RandomItems) begin
      phase = phase_e'((sent * 4) / RandomItems);
      case (phase)
        PhaseSteady: begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        PhaseSenderIdle: begin
          send_idle_pct = 62; recv_stall_pct = 0;
        end
        PhaseRecvStall: begin
          send_idle_pct = 0; recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 35; recv_stall_pct = 35;
        end
      endcase
      if ($urandom_range(9) == 0) begin
        // noise item the block ignores
        send_item('{8'($urandom), 1'b0, 1'b0});
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
      send_message(len, $urandom_range(3) == 0);
      sent += len + 1;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
